/* sv/psds_pkg.sv */
// ----------------------------------------------------------------------------
// psds_pkg
// Shared types, constants and helpers for the stroke dash segmenter.
// ----------------------------------------------------------------------------
package psds_pkg;

  localparam int COORD_W     = 24;
  localparam int LEN_W       = COORD_W + 1;
  localparam int PROD_W      = 2 * COORD_W + 1;
  localparam int DASH_N      = 8;
  localparam int DASH_W      = 16;
  localparam int CYC_W       = DASH_W + 3;
  localparam int PER_W       = CYC_W + 1;
  localparam int DSTEP_W     = 5;
  localparam int DEF_MAX_PIECES = 64;

  localparam logic [2:0] REG_DASH_COUNT = 3'd0;
  localparam logic [2:0] REG_DASH_LO    = 3'd1;
  localparam logic [2:0] REG_DASH_HI    = 3'd2;
  localparam logic [2:0] REG_DASH_OFS   = 3'd3;
  localparam logic [2:0] REG_STROKE     = 3'd4;

  localparam logic [1:0] FN_BEGIN = 2'd0;
  localparam logic [1:0] FN_MOVE  = 2'd1;
  localparam logic [1:0] FN_LINE  = 2'd2;
  localparam logic [1:0] FN_CLOSE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SQX, S_SQY, S_SQRT, S_SQFIN, S_CHECK, S_SKIPW,
    S_STEP, S_IMUL, S_IDIV, S_IWAIT, S_PUSH, S_FLUSH
  } state_t;

  typedef struct packed {
    logic               start;
    logic [LEN_W-1:0]   rem_init;
    logic [LEN_W-1:0]   num;
    logic [DSTEP_W-1:0] steps;
    logic [LEN_W-1:0]   dvs;
  } div_req_t;

  function automatic logic [DASH_W-1:0] entry_len(input logic [63:0] lo,
                                                  input logic [63:0] hi,
                                                  input logic [2:0]  i);
    logic [127:0] all;
    all = {hi, lo};
    return all[{i, 4'b0000} +: DASH_W];
  endfunction

endpackage

/* sv/path_stroke_dash_segmenter_top.sv */
// ----------------------------------------------------------------------------
// path_stroke_dash_segmenter_top
// Path command stream in, solid segments and dash pieces out.
// ----------------------------------------------------------------------------
// in_*  : one path command per item (begin, move, line, close) with a Q15.8
//         point. in_tready is high only while the sequencer is idle.
// out_* : one segment per item; tlast marks the final segment of a command,
//         tuser[1] flags pieces dropped beyond MAX_PIECES on that final one.
// cfg_* : APB registers, 64-bit data at 8-byte spacing; write only when idle.
// Sequence: begin and move give nothing. A line first sums the pattern in the
// setup state; a solid line then pushes its segment and flushes, and a close
// pushes and flushes (it only flushes when the points match). A dashed line
// squares the deltas and takes the bit-serial square root, then steps through
// the pattern; each visible piece needs four endpoint coordinates (one
// multiply, one divider start and a wait on the shared divider each) and one
// push. Skipping whole pattern periods uses the same divider. Ending the line
// flushes the held segment.
// One finished segment is held back so tlast can be set; a stalled receiver
// holds the sequencer at its next push or flush. Reset clears the path state,
// loads the dash phase to its start and the registers to their defaults.
// ----------------------------------------------------------------------------
module path_stroke_dash_segmenter_top #(
  parameter int MAX_PIECES = psds_pkg::DEF_MAX_PIECES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // pt_x[23:0], pt_y[47:24]
  input  logic [1:0]   in_tuser,   // func[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // seg_x0, seg_y0, seg_x1, seg_y1
  output logic [1:0]   out_tuser,  // solid_piece[0], pieces_dropped[1]
  output logic         out_tlast,  // last_piece
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int CW  = psds_pkg::COORD_W;
  localparam int LW  = psds_pkg::LEN_W;
  localparam int PW  = psds_pkg::PROD_W;
  localparam int DW  = psds_pkg::DASH_W;
  localparam int CNT_W = $clog2(MAX_PIECES + 1);

  psds_pkg::state_t state_r, state_nxt;

  logic [3:0]  dash_count_r;
  logic [63:0] dash_lo_r, dash_hi_r;
  logic [15:0] dash_ofs_r;
  logic        stroke_r;

  logic signed [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0] st_x_r, st_x_nxt, st_y_r, st_y_nxt;
  logic [DW-1:0] dpos_r, dpos_nxt;
  logic [2:0]    didx_r, didx_nxt;
  logic          dvis_r, dvis_nxt;

  logic [1:0]    func_r, func_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [3:0]    n_r, n_nxt;
  logic [psds_pkg::CYC_W-1:0] cyc_r, cyc_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [CW-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic          dxn_r, dxn_nxt, dyn_r, dyn_nxt;
  logic [PW-1:0] sq_r, sq_nxt, res_r, res_nxt, sbit_r, sbit_nxt, prod_r, prod_nxt;
  logic [LW-1:0] len_r, len_nxt, pos_r, pos_nxt, pa_r, pa_nxt, pb_r, pb_nxt;
  logic [1:0]    j_r, j_nxt;
  logic          dashed_r, dashed_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;

  logic [CW-1:0] sx0_r, sx0_nxt, sy0_r, sy0_nxt, sx1_r, sx1_nxt, sy1_r, sy1_nxt;
  logic          ssol_r, ssol_nxt;
  logic [95:0]   pend_r, pend_nxt;
  logic          pend_sol_r, pend_sol_nxt, pend_v_r, pend_v_nxt;

  logic          out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [95:0]   out_d_r, out_d_nxt;
  logic [1:0]    out_u_r, out_u_nxt;

  logic [CW-1:0] mul_a;
  logic [LW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic signed [LW-1:0] dx_c, dy_c;
  logic [CW-1:0] ax_c, ay_c;
  logic [psds_pkg::PER_W-1:0] period_c;
  logic          any_c, skip_c, dashing_c, out_free, cfg_wr;
  logic [LW-1:0] rest_c, off_c, len_c;
  logic [PW-1:0] sqt_c;
  logic [DW-1:0] el_c, remn_c, adv_c;
  logic [DW:0]   dsum_c;
  logic signed [LW-1:0] crd_c;
  logic [LW:0]   rem2_c;
  logic          div_done;
  logic [LW-1:0] div_quo, div_rem;
  psds_pkg::div_req_t div_req;

  psds_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_paddr[5:3])
      psds_pkg::REG_DASH_COUNT: cfg_prdata = {60'd0, dash_count_r};
      psds_pkg::REG_DASH_LO:    cfg_prdata = dash_lo_r;
      psds_pkg::REG_DASH_HI:    cfg_prdata = dash_hi_r;
      psds_pkg::REG_DASH_OFS:   cfg_prdata = {48'd0, dash_ofs_r};
      psds_pkg::REG_STROKE:     cfg_prdata = {63'd0, stroke_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  // shared datapath
  always_comb begin
    dx_c = {px_r[CW-1], px_r} - {cur_x_r[CW-1], cur_x_r};
    dy_c = {py_r[CW-1], py_r} - {cur_y_r[CW-1], cur_y_r};
    ax_c = dx_c[LW-1] ? CW'(-dx_c) : CW'(dx_c);
    ay_c = dy_c[LW-1] ? CW'(-dy_c) : CW'(dy_c);
    case (state_r)
      psds_pkg::S_SQX: begin
        mul_a = ax_c;
        mul_b = {1'b0, ax_c};
      end
      psds_pkg::S_SQY: begin
        mul_a = ay_r;
        mul_b = {1'b0, ay_r};
      end
      default: begin
        mul_a = j_r[0] ? ay_r : ax_r;
        mul_b = j_r[1] ? pb_r : pa_r;
      end
    endcase
    mul_p = PW'(mul_a * mul_b);

    period_c = n_r[0] ? {cyc_r, 1'b0} : {1'b0, cyc_r};
    any_c = n_r[0];
    for (int k = 0; k < psds_pkg::DASH_N; k++) begin
      if ((4'(k) < n_r) && (psds_pkg::entry_len(dash_lo_r, dash_hi_r, 3'(k)) != '0) &&
          (dvis_r ^ k[0] ^ idx_r[0]))
        any_c = 1'b1;
    end
    rest_c = len_r - pos_r;
    skip_c = (dpos_r == '0) && (rest_c > LW'(period_c)) &&
             (!any_c || (cnt_r >= CNT_W'(MAX_PIECES)));
    dashing_c = (n_r >= 4'd2) && stroke_r && (cyc_r != '0);

    sqt_c = res_r + sbit_r;
    len_c = LW'(res_r) + LW'(sq_r > res_r);

    el_c   = psds_pkg::entry_len(dash_lo_r, dash_hi_r, idx_r);
    remn_c = (el_c > dpos_r) ? el_c - dpos_r : '0;
    adv_c  = (rest_c < LW'(remn_c)) ? DW'(rest_c) : remn_c;
    dsum_c = {1'b0, dpos_r} + {1'b0, adv_c};

    rem2_c = {div_rem, 1'b0};
    off_c  = div_quo + LW'(rem2_c >= {1'b0, len_r});
    if (j_r[0])
      crd_c = dyn_r ? {cur_y_r[CW-1], cur_y_r} - off_c : {cur_y_r[CW-1], cur_y_r} + off_c;
    else
      crd_c = dxn_r ? {cur_x_r[CW-1], cur_x_r} - off_c : {cur_x_r[CW-1], cur_x_r} + off_c;

    div_req.start    = (state_r == psds_pkg::S_IDIV) ||
                       ((state_r == psds_pkg::S_CHECK) && (pos_r < len_r) && skip_c);
    if (state_r == psds_pkg::S_IDIV) begin
      div_req.rem_init = prod_r[PW-1:CW];
      div_req.num      = {prod_r[CW-1:0], 1'b0};
      div_req.steps    = psds_pkg::DSTEP_W'(CW);
      div_req.dvs      = len_r;
    end else begin
      div_req.rem_init = '0;
      div_req.num      = rest_c - 1'b1;
      div_req.steps    = psds_pkg::DSTEP_W'(LW);
      div_req.dvs      = LW'(period_c);
    end

    out_free = !out_v_r || out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psds_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            psds_pkg::FN_LINE:  state_nxt = psds_pkg::S_PREP;
            psds_pkg::FN_CLOSE: state_nxt = (cur_x_r != st_x_r || cur_y_r != st_y_r) ?
                                            psds_pkg::S_PUSH : psds_pkg::S_FLUSH;
            default:            state_nxt = psds_pkg::S_IDLE;
          endcase
        end
      end
      psds_pkg::S_PREP:  if (k_r == 3'd7) state_nxt = psds_pkg::S_SQX;
      psds_pkg::S_SQX:   state_nxt = dashing_c ? psds_pkg::S_SQY : psds_pkg::S_PUSH;
      psds_pkg::S_SQY:   state_nxt = psds_pkg::S_SQRT;
      psds_pkg::S_SQRT:  if (sbit_r[0]) state_nxt = psds_pkg::S_SQFIN;
      psds_pkg::S_SQFIN: state_nxt = (len_c == '0) ? psds_pkg::S_FLUSH : psds_pkg::S_CHECK;
      psds_pkg::S_CHECK: begin
        if (pos_r >= len_r)
          state_nxt = psds_pkg::S_FLUSH;
        else if (skip_c)
          state_nxt = psds_pkg::S_SKIPW;
        else
          state_nxt = psds_pkg::S_STEP;
      end
      psds_pkg::S_SKIPW: if (div_done) state_nxt = psds_pkg::S_STEP;
      psds_pkg::S_STEP: begin
        if (dvis_r && (adv_c != '0) && (cnt_r < CNT_W'(MAX_PIECES)))
          state_nxt = psds_pkg::S_IMUL;
        else
          state_nxt = psds_pkg::S_CHECK;
      end
      psds_pkg::S_IMUL:  state_nxt = psds_pkg::S_IDIV;
      psds_pkg::S_IDIV:  state_nxt = psds_pkg::S_IWAIT;
      psds_pkg::S_IWAIT: begin
        if (div_done)
          state_nxt = (j_r == 2'd3) ? psds_pkg::S_PUSH : psds_pkg::S_IMUL;
      end
      psds_pkg::S_PUSH: begin
        if (!pend_v_r || out_free)
          state_nxt = dashed_r ? psds_pkg::S_CHECK : psds_pkg::S_FLUSH;
      end
      psds_pkg::S_FLUSH: if (!pend_v_r || out_free) state_nxt = psds_pkg::S_IDLE;
      default: state_nxt = psds_pkg::S_IDLE;
    endcase
  end

  // register updates
  always_comb begin
    cur_x_nxt = cur_x_r;  cur_y_nxt = cur_y_r;
    st_x_nxt  = st_x_r;   st_y_nxt  = st_y_r;
    dpos_nxt  = dpos_r;   didx_nxt  = didx_r;   dvis_nxt = dvis_r;
    func_nxt  = func_r;   px_nxt    = px_r;     py_nxt   = py_r;
    n_nxt     = n_r;      cyc_nxt   = cyc_r;    k_nxt    = k_r;
    idx_nxt   = idx_r;    ax_nxt    = ax_r;     ay_nxt   = ay_r;
    dxn_nxt   = dxn_r;    dyn_nxt   = dyn_r;    sq_nxt   = sq_r;
    res_nxt   = res_r;    sbit_nxt  = sbit_r;   prod_nxt = prod_r;
    len_nxt   = len_r;    pos_nxt   = pos_r;    pa_nxt   = pa_r;
    pb_nxt    = pb_r;     j_nxt     = j_r;      dashed_nxt = dashed_r;
    cnt_nxt   = cnt_r;    drop_nxt  = drop_r;
    sx0_nxt   = sx0_r;    sy0_nxt   = sy0_r;    sx1_nxt  = sx1_r;
    sy1_nxt   = sy1_r;    ssol_nxt  = ssol_r;
    pend_nxt  = pend_r;   pend_sol_nxt = pend_sol_r; pend_v_nxt = pend_v_r;
    out_v_nxt = out_v_r & ~out_tready;
    out_d_nxt = out_d_r;  out_u_nxt = out_u_r;  out_last_nxt = out_last_r;

    case (state_r)
      psds_pkg::S_IDLE: begin
        if (in_tvalid) begin
          func_nxt = in_tuser;
          px_nxt   = in_tdata[CW-1:0];
          py_nxt   = in_tdata[2*CW-1:CW];
          cnt_nxt  = '0;
          drop_nxt = 1'b0;
          case (in_tuser)
            psds_pkg::FN_BEGIN: begin
              cur_x_nxt = '0;  cur_y_nxt = '0;
              st_x_nxt  = '0;  st_y_nxt  = '0;
              dpos_nxt  = dash_ofs_r;
              didx_nxt  = '0;
              dvis_nxt  = 1'b1;
            end
            psds_pkg::FN_MOVE: begin
              cur_x_nxt = in_tdata[CW-1:0];
              st_x_nxt  = in_tdata[CW-1:0];
              cur_y_nxt = in_tdata[2*CW-1:CW];
              st_y_nxt  = in_tdata[2*CW-1:CW];
            end
            psds_pkg::FN_LINE: begin
              n_nxt   = (dash_count_r > 4'(psds_pkg::DASH_N)) ?
                        4'(psds_pkg::DASH_N) : dash_count_r;
              k_nxt   = '0;
              cyc_nxt = '0;
              idx_nxt = didx_r;
            end
            default: begin
              sx0_nxt = cur_x_r;  sy0_nxt = cur_y_r;
              sx1_nxt = st_x_r;   sy1_nxt = st_y_r;
              ssol_nxt = 1'b1;
              dashed_nxt = 1'b0;
            end
          endcase
        end
      end
      psds_pkg::S_PREP: begin
        if ({1'b0, k_r} < n_r)
          cyc_nxt = cyc_r + psds_pkg::CYC_W'(psds_pkg::entry_len(dash_lo_r, dash_hi_r, k_r));
        if ({1'b0, idx_r} >= n_r)
          idx_nxt = idx_r - n_r[2:0];
        k_nxt = k_r + 1'b1;
      end
      psds_pkg::S_SQX: begin
        if (dashing_c) begin
          ax_nxt  = ax_c;
          ay_nxt  = ay_c;
          dxn_nxt = dx_c[LW-1];
          dyn_nxt = dy_c[LW-1];
          sq_nxt  = mul_p;
        end else begin
          sx0_nxt = cur_x_r;  sy0_nxt = cur_y_r;
          sx1_nxt = px_r;     sy1_nxt = py_r;
          ssol_nxt = 1'b1;
          dashed_nxt = 1'b0;
        end
      end
      psds_pkg::S_SQY: begin
        sq_nxt   = sq_r + mul_p;
        res_nxt  = '0;
        sbit_nxt = PW'(1) << (PW - 1);
      end
      psds_pkg::S_SQRT: begin
        if (sq_r >= sqt_c) begin
          sq_nxt  = sq_r - sqt_c;
          res_nxt = (res_r >> 1) + sbit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
      end
      psds_pkg::S_SQFIN: begin
        len_nxt    = len_c;
        pos_nxt    = '0;
        dashed_nxt = 1'b1;
      end
      psds_pkg::S_CHECK: begin
        if (pos_r >= len_r)
          didx_nxt = idx_r;
        else if (skip_c && any_c)
          drop_nxt = 1'b1;
      end
      psds_pkg::S_SKIPW: begin
        if (div_done)
          pos_nxt = len_r - 1'b1 - div_rem;
      end
      psds_pkg::S_STEP: begin
        pa_nxt  = pos_r;
        pb_nxt  = pos_r + LW'(adv_c);
        pos_nxt = pos_r + LW'(adv_c);
        j_nxt   = '0;
        ssol_nxt = 1'b0;
        if (dvis_r && (adv_c != '0) && (cnt_r >= CNT_W'(MAX_PIECES)))
          drop_nxt = 1'b1;
        if (dsum_c >= {1'b0, el_c}) begin
          dpos_nxt = '0;
          idx_nxt  = ({1'b0, idx_r} + 4'd1 == n_r) ? 3'd0 : idx_r + 3'd1;
          dvis_nxt = !dvis_r;
        end else begin
          dpos_nxt = dsum_c[DW-1:0];
        end
      end
      psds_pkg::S_IMUL: prod_nxt = mul_p;
      psds_pkg::S_IWAIT: begin
        if (div_done) begin
          case (j_r)
            2'd0:    sx0_nxt = crd_c[CW-1:0];
            2'd1:    sy0_nxt = crd_c[CW-1:0];
            2'd2:    sx1_nxt = crd_c[CW-1:0];
            default: sy1_nxt = crd_c[CW-1:0];
          endcase
          j_nxt = j_r + 1'b1;
        end
      end
      psds_pkg::S_PUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_d_nxt    = pend_r;
            out_u_nxt    = {1'b0, pend_sol_r};
            out_last_nxt = 1'b0;
          end
          pend_nxt     = {sy1_r, sx1_r, sy0_r, sx0_r};
          pend_sol_nxt = ssol_r;
          pend_v_nxt   = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      psds_pkg::S_FLUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_d_nxt    = pend_r;
            out_u_nxt    = {drop_r, pend_sol_r};
            out_last_nxt = 1'b1;
            pend_v_nxt   = 1'b0;
          end
          if (func_r == psds_pkg::FN_LINE) begin
            cur_x_nxt = px_r;
            cur_y_nxt = py_r;
          end else if (func_r == psds_pkg::FN_CLOSE) begin
            cur_x_nxt = st_x_r;
            cur_y_nxt = st_y_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psds_pkg::S_IDLE;
      dash_count_r <= '0;
      dash_lo_r    <= '0;
      dash_hi_r    <= '0;
      dash_ofs_r   <= '0;
      stroke_r     <= 1'b1;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      st_x_r       <= '0;
      st_y_r       <= '0;
      dpos_r       <= '0;
      didx_r       <= '0;
      dvis_r       <= 1'b1;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      st_x_r   <= st_x_nxt;
      st_y_r   <= st_y_nxt;
      dpos_r   <= dpos_nxt;
      didx_r   <= didx_nxt;
      dvis_r   <= dvis_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[5:3])
          psds_pkg::REG_DASH_COUNT: dash_count_r <= cfg_pwdata[3:0];
          psds_pkg::REG_DASH_LO:    dash_lo_r    <= cfg_pwdata;
          psds_pkg::REG_DASH_HI:    dash_hi_r    <= cfg_pwdata;
          psds_pkg::REG_DASH_OFS:   dash_ofs_r   <= cfg_pwdata[15:0];
          psds_pkg::REG_STROKE:     stroke_r     <= cfg_pwdata[0];
          default: ;
        endcase
      end
    end
    func_r   <= func_nxt;   px_r    <= px_nxt;    py_r   <= py_nxt;
    n_r      <= n_nxt;      cyc_r   <= cyc_nxt;   k_r    <= k_nxt;
    idx_r    <= idx_nxt;    ax_r    <= ax_nxt;    ay_r   <= ay_nxt;
    dxn_r    <= dxn_nxt;    dyn_r   <= dyn_nxt;   sq_r   <= sq_nxt;
    res_r    <= res_nxt;    sbit_r  <= sbit_nxt;  prod_r <= prod_nxt;
    len_r    <= len_nxt;    pos_r   <= pos_nxt;   pa_r   <= pa_nxt;
    pb_r     <= pb_nxt;     j_r     <= j_nxt;     dashed_r <= dashed_nxt;
    cnt_r    <= cnt_nxt;    drop_r  <= drop_nxt;
    sx0_r    <= sx0_nxt;    sy0_r   <= sy0_nxt;   sx1_r  <= sx1_nxt;
    sy1_r    <= sy1_nxt;    ssol_r  <= ssol_nxt;
    pend_r   <= pend_nxt;   pend_sol_r <= pend_sol_nxt;
    out_d_r  <= out_d_nxt;  out_u_r <= out_u_nxt; out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == psds_pkg::S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/psds_div.sv */
// ----------------------------------------------------------------------------
// psds_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psds_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  psds_pkg::div_req_t       req,
  output logic                     done,
  output logic [psds_pkg::LEN_W-1:0] quo,
  output logic [psds_pkg::LEN_W-1:0] rem
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [psds_pkg::DSTEP_W-1:0]     cnt_r, cnt_nxt;
  logic [psds_pkg::LEN_W-1:0]       rem_r, rem_nxt;
  logic [psds_pkg::LEN_W-1:0]       num_r, num_nxt;
  logic [psds_pkg::LEN_W-1:0]       quo_r, quo_nxt;
  logic [psds_pkg::LEN_W-1:0]       dvs_r, dvs_nxt;
  logic [psds_pkg::LEN_W:0]         r2;
  logic                             ge;

  always_comb begin
    r2 = {rem_r, num_r[psds_pkg::LEN_W-1]};
    ge = r2 >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      num_nxt  = req.num;
      dvs_nxt  = req.dvs;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? psds_pkg::LEN_W'(r2 - {1'b0, dvs_r}) : r2[psds_pkg::LEN_W-1:0];
      quo_nxt = {quo_r[psds_pkg::LEN_W-2:0], ge};
      num_nxt = {num_r[psds_pkg::LEN_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == psds_pkg::DSTEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams path commands into the dash segmenter and checks every segment
// against a cycle-free predictor of the segmenting rules, or against a typed
// segment where a directed row gives one. Directed rows cover extremes and
// corner cases; random phases vary dash settings and sender/receiver idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] x0, y0, x1, y1;
    logic        solid, last, dropped;
  } seg_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [63:0] value;
    logic [1:0]  fn;
    logic [23:0] x, y;
    bit          typed;
    seg_t        seg;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [5:0]  cfg_paddr;
  logic [63:0] cfg_pwdata, cfg_prdata;

  path_stroke_dash_segmenter_top dut (.*);

  always #1 clk = ~clk;

  // predictor state and register shadow
  logic [3:0]  r_count;
  logic [63:0] r_lo, r_hi;
  logic [15:0] r_offset;
  logic        r_stroke;
  longint      cur_x, cur_y, start_x, start_y;
  int unsigned dash_pos, dash_idx;
  bit          dash_vis;

  seg_t cmd_segs[$];
  bit   cmd_dropped;
  seg_t expected_segs[$];
  int   errors = 0;
  int   idle_pct = 0, stall_pct = 0;
  row_t rows[$];

  function automatic int unsigned entry_length(int unsigned i);
    if (i < 4) return r_lo[16*i +: 16];
    if (i < 8) return r_hi[16*(i-4) +: 16];
    return 0;
  endfunction

  function automatic longint unsigned isqrt_round(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (v > res) res++;
    return res;
  endfunction

  function automatic longint unsigned mul_div_round(longint unsigned a, longint unsigned b,
                                                    longint unsigned c);
    logic [127:0] prod, q, r;
    prod = 128'(a) * 128'(b);
    q = prod / 128'(c);
    r = prod % 128'(c);
    if (2 * r >= 128'(c)) q++;
    return q[63:0];
  endfunction

  function automatic longint interp(longint p0, longint d, longint unsigned p,
                                    longint unsigned len);
    longint unsigned mag;
    longint off;
    mag = d < 0 ? longint'(-d) : longint'(d);
    off = longint'(mul_div_round(mag, p, len));
    return d < 0 ? p0 - off : p0 + off;
  endfunction

  task automatic add_seg(longint x0, longint y0, longint x1, longint y1, bit solid);
    seg_t s;
    if (cmd_segs.size() >= psds_pkg::DEF_MAX_PIECES) begin
      cmd_dropped = 1;
      return;
    end
    s.x0 = x0[23:0]; s.y0 = y0[23:0]; s.x1 = x1[23:0]; s.y1 = y1[23:0];
    s.solid = solid; s.last = 0; s.dropped = 0;
    cmd_segs.insert(cmd_segs.size(), s);
  endtask

  task automatic cut_dashes(longint x1, longint y1, int unsigned n, longint unsigned cycle);
    longint dx, dy;
    longint unsigned ax, ay, len, pos, period, adv;
    int unsigned s, idx, el, remaining, j, steps;
    bit any, vis;
    dx = x1 - cur_x;
    dy = y1 - cur_y;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    pos = 0;
    s = 0;
    period = n[0] ? 2 * cycle : cycle;
    idx = dash_idx % n;
    while ((ax | ay) >= 64'h8000_0000) begin
      ax >>= 1;
      ay >>= 1;
      s++;
    end
    len = isqrt_round(ax * ax + ay * ay) << s;
    if (len == 0) return;
    while (pos < len) begin
      if (dash_pos == 0 && len - pos > period) begin
        any = 0;
        steps = n[0] ? 2 * n : n;
        for (j = 0; j < steps; j++) begin
          vis = dash_vis != j[0];
          if (vis && entry_length((idx + j) % n) > 0) any = 1;
        end
        if (!any || cmd_segs.size() >= psds_pkg::DEF_MAX_PIECES) begin
          pos += ((len - pos - 1) / period) * period;
          if (any) cmd_dropped = 1;
        end
      end
      el = entry_length(idx);
      remaining = el > dash_pos ? el - dash_pos : 0;
      adv = len - pos;
      if (longint'(remaining) < adv) adv = remaining;
      if (dash_vis && adv > 0)
        add_seg(interp(cur_x, dx, pos, len), interp(cur_y, dy, pos, len),
                interp(cur_x, dx, pos + adv, len), interp(cur_y, dy, pos + adv, len), 0);
      pos += adv;
      dash_pos += int'(adv);
      if (dash_pos >= el) begin
        dash_pos = 0;
        idx = (idx + 1) % n;
        dash_vis = !dash_vis;
      end
    end
    dash_idx = idx;
  endtask

  task automatic segment_command(logic [1:0] fn, logic [23:0] x, logic [23:0] y);
    longint px, py;
    longint unsigned cycle;
    int unsigned n, i;
    px = longint'($signed(x));
    py = longint'($signed(y));
    cmd_segs.delete();
    cmd_dropped = 0;
    case (fn)
      psds_pkg::FN_BEGIN: begin
        cur_x = 0; cur_y = 0; start_x = 0; start_y = 0;
        dash_pos = r_offset; dash_idx = 0; dash_vis = 1;
      end
      psds_pkg::FN_MOVE: begin
        cur_x = px; start_x = px; cur_y = py; start_y = py;
      end
      psds_pkg::FN_LINE: begin
        n = r_count > 8 ? 8 : r_count;
        cycle = 0;
        for (i = 0; i < n; i++) cycle += entry_length(i);
        if (n >= 2 && r_stroke && cycle > 0) cut_dashes(px, py, n, cycle);
        else add_seg(cur_x, cur_y, px, py, 1);
        cur_x = px; cur_y = py;
      end
      default: begin
        if (cur_x != start_x || cur_y != start_y) add_seg(cur_x, cur_y, start_x, start_y, 1);
        cur_x = start_x; cur_y = start_y;
      end
    endcase
    if (cmd_segs.size() > 0) begin
      cmd_segs[cmd_segs.size()-1].last = 1;
      cmd_segs[cmd_segs.size()-1].dropped = cmd_dropped;
    end
  endtask

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0;
    case (idx)
      psds_pkg::REG_DASH_COUNT: r_count = val[3:0];
      psds_pkg::REG_DASH_LO:    r_lo = val;
      psds_pkg::REG_DASH_HI:    r_hi = val;
      psds_pkg::REG_DASH_OFS:   r_offset = val[15:0];
      psds_pkg::REG_STROKE:     r_stroke = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_command(logic [1:0] fn, logic [23:0] x, logic [23:0] y,
                              bit typed, seg_t typed_seg);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= fn;
    in_tdata <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    segment_command(fn, x, y);
    if (typed) expected_segs.insert(expected_segs.size(), typed_seg);
    else foreach (cmd_segs[k]) expected_segs.insert(expected_segs.size(), cmd_segs[k]);
  endtask

  function automatic row_t cfg_row(logic [2:0] idx, logic [63:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1; r.reg_idx = idx; r.value = val;
    return r;
  endfunction

  function automatic row_t cmd_row(logic [1:0] fn, int x, int y);
    row_t r;
    r = '{default: '0};
    r.fn = fn; r.x = x[23:0]; r.y = y[23:0];
    return r;
  endfunction

  function automatic row_t chk_row(logic [1:0] fn, int x, int y,
                                   int x0, int y0, int x1, int y1);
    row_t r;
    r = cmd_row(fn, x, y);
    r.typed = 1;
    r.seg = '{x0[23:0], y0[23:0], x1[23:0], y1[23:0], 1'b1, 1'b1, 1'b0};
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows.insert(rows.size(), r);
  endfunction

  function automatic logic [15:0] rand_entry();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 16'h0000;
    if (p < 14) return 16'hFFFF;
    if (p < 18) return 16'($urandom);
    return 16'($urandom_range(16'h0080, 16'h0400));
  endfunction

  function automatic logic [23:0] rand_coord();
    if ($urandom_range(0, 99) < 8) return 24'($urandom);
    return 24'($urandom_range(0, 4095) - 2048);
  endfunction

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    seg_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[23:0], out_tdata[47:24], out_tdata[71:48], out_tdata[95:72],
             out_tuser[0], out_tlast, out_tuser[1]};
      if (expected_segs.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment %h", $realtime, got);
      end else begin
        want = expected_segs.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: segment mismatch expected %h %h %h %h s%b l%b d%b", $realtime,
                   want.x0, want.y0, want.x1, want.y1, want.solid, want.last, want.dropped);
          $display("%0t:                  actual   %h %h %h %h s%b l%b d%b", $realtime,
                   got.x0, got.y0, got.x1, got.y1, got.solid, got.last, got.dropped);
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int n_rand;
    logic [63:0] v;
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    r_count = 0; r_lo = 0; r_hi = 0; r_offset = 0; r_stroke = 1;
    cur_x = 0; cur_y = 0; start_x = 0; start_y = 0;
    dash_pos = 0; dash_idx = 0; dash_vis = 1;

    add_row(chk_row(psds_pkg::FN_LINE, 256, 0, 0, 0, 256, 0));
    add_row(chk_row(psds_pkg::FN_CLOSE, 0, 0, 256, 0, 0, 0));
    add_row(cmd_row(psds_pkg::FN_CLOSE, 0, 0));
    add_row(cmd_row(psds_pkg::FN_MOVE, -8388608, -8388608));
    add_row(chk_row(psds_pkg::FN_LINE, 8388607, 8388607,
                    -8388608, -8388608, 8388607, 8388607));
    add_row(chk_row(psds_pkg::FN_LINE, 8388607, 8388607,
                    8388607, 8388607, 8388607, 8388607));
    add_row(cfg_row(psds_pkg::REG_DASH_COUNT, 2));
    add_row(cfg_row(psds_pkg::REG_DASH_LO, 64'h0000_0000_0100_0100));
    add_row(cmd_row(psds_pkg::FN_BEGIN, 0, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 1024, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 0, 768));
    add_row(cmd_row(psds_pkg::FN_CLOSE, 0, 0));
    add_row(cmd_row(psds_pkg::FN_MOVE, -8388608, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 8388607, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 8388607, 0));
    add_row(cfg_row(psds_pkg::REG_DASH_OFS, 64'hFFFF));
    add_row(cmd_row(psds_pkg::FN_BEGIN, 0, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 2000, 300));
    add_row(cfg_row(psds_pkg::REG_DASH_COUNT, 3));
    add_row(cfg_row(psds_pkg::REG_DASH_LO, 64'h0000_0080_0000_0200));
    add_row(cmd_row(psds_pkg::FN_BEGIN, 0, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 3000, -1000));
    add_row(cfg_row(psds_pkg::REG_DASH_COUNT, 15));
    add_row(cfg_row(psds_pkg::REG_DASH_HI, 64'hFFFF_0000_0040_0100));
    add_row(cmd_row(psds_pkg::FN_LINE, -5000, 5000));
    add_row(cfg_row(psds_pkg::REG_STROKE, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 0, 0));
    add_row(cfg_row(psds_pkg::REG_STROKE, 1));
    add_row(cfg_row(psds_pkg::REG_DASH_LO, 0));
    add_row(cfg_row(psds_pkg::REG_DASH_HI, 0));
    add_row(cmd_row(psds_pkg::FN_LINE, 100, 100));
    add_row(cfg_row(psds_pkg::REG_DASH_COUNT, 1));
    add_row(cfg_row(psds_pkg::REG_DASH_LO, 64'h0100));
    add_row(cmd_row(psds_pkg::FN_LINE, -300, 77));
    add_row(cmd_row(psds_pkg::FN_CLOSE, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_idle();
        reg_write(rows[i].reg_idx, rows[i].value);
      end else begin
        send_command(rows[i].fn, rows[i].x, rows[i].y, rows[i].typed, rows[i].seg);
      end
    end

    n_rand = 0;
    for (int ph = 0; n_rand < 250; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 15;
        2: v = 8;
        3: v = $urandom_range(0, 15);
        default: v = $urandom_range(2, 8);
      endcase
      reg_write(psds_pkg::REG_DASH_COUNT, v);
      reg_write(psds_pkg::REG_DASH_LO,
                {rand_entry(), rand_entry(), rand_entry(), rand_entry()});
      reg_write(psds_pkg::REG_DASH_HI,
                {rand_entry(), rand_entry(), rand_entry(), rand_entry()});
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 16'hFFFF;
        2: v = $urandom;
        default: v = $urandom_range(0, 16'h0200);
      endcase
      reg_write(psds_pkg::REG_DASH_OFS, v);
      reg_write(psds_pkg::REG_STROKE, $urandom_range(0, 99) < 85 ? 64'd1 : 64'd0);
      for (int k = 0; k < 21; k++) begin
        int unsigned p;
        logic [1:0] fn;
        p = $urandom_range(0, 99);
        fn = p < 8 ? psds_pkg::FN_BEGIN : p < 22 ? psds_pkg::FN_MOVE :
             p < 82 ? psds_pkg::FN_LINE : psds_pkg::FN_CLOSE;
        send_command(fn, rand_coord(), rand_coord(), 0, '0);
        n_rand++;
      end
    end

    in_tvalid <= 0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/psds_pkg.sv
sv/psds_div.sv
sv/path_stroke_dash_segmenter_top.sv
dv/testbench.sv
